// ===== rtl/indexed_list_insert_delete_top_assert.svh =====
// assertion helpers, sampled on clk and quiet while rst_n is low
`ifndef INDEXED_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define ILID_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ILID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ilid_pkg.sv =====
`default_nettype none

package ilid_pkg;

    localparam int IDX_W = 7;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int CNT_W = 7;

    localparam logic [2:0] OP_READ = 3'd0;
    localparam logic [2:0] OP_HEAD = 3'd1;
    localparam logic [2:0] OP_TAIL = 3'd2;
    localparam logic [2:0] OP_AT   = 3'd3;
    localparam logic [2:0] OP_DEL  = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [VAL_W-1:0] RD_FAIL = -32'sd1;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_INS,
        SH_DEL
    } shift_t;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_LEN,
        POS_IDX
    } pos_sel_t;

    typedef struct packed {
        logic             exec;
        shift_t           shift;
        pos_sel_t         pos_sel;
        logic             rd;
        logic             rd_fail;
        logic [ST_W-1:0]  status;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ilid_req_if.sv =====
`default_nettype none

interface ilid_req_if;
    logic                               valid;
    logic                               ready;
    logic [2:0]                         op;
    logic [ilid_pkg::IDX_W-1:0]         index;
    logic signed [ilid_pkg::VAL_W-1:0]  value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink (input valid, input op, input index, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/ilid_rsp_if.sv =====
`default_nettype none

interface ilid_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [ilid_pkg::VAL_W-1:0]  read_value;
    logic [ilid_pkg::ST_W-1:0]          status;
    logic [ilid_pkg::CNT_W-1:0]         count;

    modport source (output valid, output read_value, output status, output count,
                    input ready);
    modport sink (input valid, input read_value, input status, input count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ilid_ctrl.sv =====
`default_nettype none

module ilid_ctrl #(
    parameter int CAPACITY = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire logic [2:0]                    op,
    input  wire logic [ilid_pkg::IDX_W-1:0]    index,
    input  wire logic [$clog2(CAPACITY+1)-1:0] length,
    output ilid_pkg::dp_cmd_t                  cmd
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CW    = (LEN_W > ilid_pkg::IDX_W) ? LEN_W : ilid_pkg::IDX_W;
    localparam logic [CW-1:0] CAP_EXT = CW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic          accept;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] idx_ext;
    logic          full;

    assign req_ready = (state_reg == S_IDLE) || rsp_ready;
    assign rsp_valid = (state_reg == S_HOLD);
    assign accept    = req_valid && req_ready;
    assign len_ext   = CW'(length);
    assign idx_ext   = CW'(index);
    assign full      = (len_ext == CAP_EXT);

    // decode the item and settle its checks before the datapath commits
    always_comb
    begin
        cmd         = '0;
        cmd.shift   = ilid_pkg::SH_NONE;
        cmd.pos_sel = ilid_pkg::POS_ZERO;
        cmd.status  = ilid_pkg::ST_DONE;
        cmd.exec    = accept;
        unique case (op)
            ilid_pkg::OP_READ:
            begin
                cmd.rd = 1'b1;
                if (idx_ext >= len_ext)
                begin
                    cmd.rd_fail = 1'b1;
                    cmd.status  = ilid_pkg::ST_RANGE;
                end
            end
            ilid_pkg::OP_HEAD:
            begin
                cmd.pos_sel = ilid_pkg::POS_ZERO;
                if (full)
                    cmd.status = ilid_pkg::ST_FULL;
                else
                    cmd.shift = ilid_pkg::SH_INS;
            end
            ilid_pkg::OP_TAIL:
            begin
                cmd.pos_sel = ilid_pkg::POS_LEN;
                if (full)
                    cmd.status = ilid_pkg::ST_FULL;
                else
                    cmd.shift = ilid_pkg::SH_INS;
            end
            ilid_pkg::OP_AT:
            begin
                cmd.pos_sel = ilid_pkg::POS_IDX;
                priority if (idx_ext > len_ext)
                    cmd.status = ilid_pkg::ST_RANGE;
                else if (full)
                    cmd.status = ilid_pkg::ST_FULL;
                else
                    cmd.shift = ilid_pkg::SH_INS;
            end
            ilid_pkg::OP_DEL:
            begin
                cmd.pos_sel = ilid_pkg::POS_IDX;
                if (idx_ext < len_ext)
                    cmd.shift = ilid_pkg::SH_DEL;
                else
                    cmd.status = ilid_pkg::ST_RANGE;
            end
            default:
            begin
                cmd.shift = ilid_pkg::SH_NONE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (accept)
            state_next = S_HOLD;
        else if (rsp_ready)
            state_next = S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/ilid_datapath.sv =====
`default_nettype none

module ilid_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ilid_pkg::dp_cmd_t                    cmd,
    input  wire logic [ilid_pkg::IDX_W-1:0]           index,
    input  wire logic signed [ilid_pkg::VAL_W-1:0]    value,
    output logic [$clog2(CAPACITY+1)-1:0]             length,
    output logic signed [ilid_pkg::VAL_W-1:0]         read_value,
    output logic [ilid_pkg::ST_W-1:0]                 status,
    output logic [ilid_pkg::CNT_W-1:0]                count
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int ADR_W = $clog2(CAPACITY);
    localparam int CW    = (LEN_W > ilid_pkg::IDX_W) ? LEN_W : ilid_pkg::IDX_W;

    logic signed [ilid_pkg::VAL_W-1:0] entry_reg  [CAPACITY];
    logic signed [ilid_pkg::VAL_W-1:0] entry_next [CAPACITY];
    logic signed [ilid_pkg::VAL_W-1:0] from_left  [CAPACITY];
    logic signed [ilid_pkg::VAL_W-1:0] from_right [CAPACITY];

    logic [LEN_W-1:0]                  length_reg;
    logic [LEN_W-1:0]                  length_next;
    logic [CW-1:0]                     len_ext;
    logic [CW-1:0]                     idx_ext;
    logic [CW-1:0]                     len_next_ext;
    logic [CW-1:0]                     pos;
    logic signed [ilid_pkg::VAL_W-1:0] rd_word;
    logic signed [ilid_pkg::VAL_W-1:0] read_value_reg;
    logic [ilid_pkg::ST_W-1:0]         status_reg;
    logic [ilid_pkg::CNT_W-1:0]        count_reg;

    assign len_ext = CW'(length_reg);
    assign idx_ext = CW'(index);
    assign length  = length_reg;

    always_comb
    begin
        unique case (cmd.pos_sel)
            ilid_pkg::POS_ZERO: pos = '0;
            ilid_pkg::POS_LEN:  pos = len_ext;
            ilid_pkg::POS_IDX:  pos = idx_ext;
            default:            pos = '0;
        endcase
    end

    // row of cells: every entry at or past pos moves by one position, all cells together
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CW-1:0] I_POS = CW'(i);

        if (i == 0)
        begin : g_first
            assign from_left[i] = value;
        end
        else
        begin : g_mid
            assign from_left[i] = entry_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign from_right[i] = entry_reg[i];
        end
        else
        begin : g_inner
            assign from_right[i] = entry_reg[i+1];
        end

        always_comb
        begin
            entry_next[i] = entry_reg[i];
            unique case (cmd.shift)
                ilid_pkg::SH_INS:
                begin
                    if (I_POS == pos)
                        entry_next[i] = value;
                    else if (I_POS > pos)
                        entry_next[i] = from_left[i];
                end
                ilid_pkg::SH_DEL:
                begin
                    if (I_POS >= pos)
                        entry_next[i] = from_right[i];
                end
                default:
                begin
                    entry_next[i] = entry_reg[i];
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (cmd.exec)
                entry_reg[i] <= entry_next[i];
        end
    end

    always_comb
    begin
        unique case (cmd.shift)
            ilid_pkg::SH_INS: length_next = length_reg + LEN_W'(1);
            ilid_pkg::SH_DEL: length_next = length_reg - LEN_W'(1);
            default:          length_next = length_reg;
        endcase
    end

    assign len_next_ext = CW'(length_next);
    // only reached on a good read, where the index lies inside the row
    assign rd_word      = entry_reg[idx_ext[ADR_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= '0;
        else if (cmd.exec)
            length_reg <= length_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (!cmd.rd)
                read_value_reg <= '0;
            else if (cmd.rd_fail)
                read_value_reg <= ilid_pkg::RD_FAIL;
            else
                read_value_reg <= rd_word;
            status_reg <= cmd.status;
            count_reg  <= len_next_ext[ilid_pkg::CNT_W-1:0];
        end
    end

    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = count_reg;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_insert_delete_top.sv =====
// Ordered list of up to CAPACITY signed 32-bit words with a count. Each item on req
// carries op (0 read, 1 insert at head, 2 append, 3 insert at index, 4 delete at
// index), index and value, and yields exactly one item on rsp with read_value, status
// (0 done, 1 index out of range, 2 list full) and the count after the command. The list
// lives in a row of register cells that all shift by one position together, so each
// command's result is registered and shows on rsp the cycle after acceptance. Since
// req stays ready whenever rsp is empty or being taken on the same edge, the block
// sustains one item per clock while rsp is not stalled. Entries need no clearing after
// reset; only positions below the count are ever read.
`default_nettype none

module indexed_list_insert_delete_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ilid_req_if.sink   req,
    ilid_rsp_if.source rsp
);

    localparam int LEN_W = $clog2(CAPACITY + 1);

    ilid_pkg::dp_cmd_t cmd;
    logic [LEN_W-1:0]  length;

    ilid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .op        (req.op),
        .index     (req.index),
        .length    (length),
        .cmd       (cmd)
    );

    ilid_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .index      (req.index),
        .value      (req.value),
        .length     (length),
        .read_value (rsp.read_value),
        .status     (rsp.status),
        .count      (rsp.count)
    );

endmodule

`default_nettype wire

// ===== rtl/ilid_checker.sv =====
`default_nettype none

`include "indexed_list_insert_delete_top_assert.svh"

module ilid_checker #(
    parameter int CAPACITY = 64
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                req_valid,
    input wire logic                                req_ready,
    input wire logic                                rsp_valid,
    input wire logic                                rsp_ready,
    input wire logic signed [ilid_pkg::VAL_W-1:0]   read_value,
    input wire logic [ilid_pkg::ST_W-1:0]           status,
    input wire logic [ilid_pkg::CNT_W-1:0]          count
);

    localparam logic [ilid_pkg::CNT_W-1:0] CAP_CNT = ilid_pkg::CNT_W'(CAPACITY % 128);

    // a new item only enters when the result register is free or draining
    `ILID_ASSERT_SAME(a_no_overrun,
        req_valid && req_ready,
        !rsp_valid || rsp_ready,
        "item accepted over a held result")

    `ILID_ASSERT_SAME(a_status_code,
        rsp_valid,
        status <= ilid_pkg::ST_FULL,
        "unknown status code")

    `ILID_ASSERT_SAME(a_full_count,
        rsp_valid && status == ilid_pkg::ST_FULL,
        count == CAP_CNT,
        "full status with list not full")

    // an error never carries a stored word
    `ILID_ASSERT_SAME(a_err_value,
        rsp_valid && status != ilid_pkg::ST_DONE,
        read_value == 0 || read_value == ilid_pkg::RD_FAIL,
        "error result with data")

    `ILID_ASSERT_NEXT(a_rsp_hold,
        rsp_valid && !rsp_ready,
        rsp_valid && $stable(read_value) && $stable(count),
        "stalled result changed")

endmodule

bind indexed_list_insert_delete_top ilid_checker #(
    .CAPACITY (CAPACITY)
) u_ilid_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .read_value (rsp.read_value),
    .status     (rsp.status),
    .count      (rsp.count)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int LIST_CAP    = 64;
    localparam int QUIET_LIMIT = 1000;
    localparam int CALM_TAIL   = 50;
    localparam int RANDOM_CMDS = 400;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;

    typedef logic [2:0]                        op_t;
    typedef logic [ilid_pkg::IDX_W-1:0]        idx_t;
    typedef logic signed [ilid_pkg::VAL_W-1:0] val_t;
    typedef logic [ilid_pkg::CNT_W-1:0]        cnt_t;

    typedef struct {
        op_t  op;
        idx_t index;
        val_t value;
        int   gap;
    } list_cmd_t;

    typedef struct packed {
        val_t                      read_value;
        logic [ilid_pkg::ST_W-1:0] status;
        cnt_t                      count;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ilid_req_if req_ch();
    ilid_rsp_if rsp_ch();

    indexed_list_insert_delete_top #(.CAPACITY(LIST_CAP)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #10 clk = ~clk;

    list_cmd_t    pending_cmds[$];
    list_result_t expected_results[$];
    val_t         stored[$];

    int gen_len = 0;
    int gap_odds = 0;
    int stall_odds = 0;
    int total_cmds = 0;
    int accepted_cmds = 0;
    int failures = 0;
    int quiet_cycles = 0;
    logic req_fire = 1'b0;

    // count as the block will see it, used only to aim indexes while generating
    function automatic void track_len(op_t op, idx_t idx);
        case (op)
            ilid_pkg::OP_HEAD, ilid_pkg::OP_TAIL: if (gen_len < LIST_CAP) gen_len++;
            ilid_pkg::OP_AT: if (int'(idx) <= gen_len && gen_len < LIST_CAP) gen_len++;
            ilid_pkg::OP_DEL: if (int'(idx) < gen_len) gen_len--;
            default: ;
        endcase
    endfunction

    function automatic void add_cmd(op_t op, idx_t idx, val_t val, int gap);
        list_cmd_t c;
        c.op = op;
        c.index = idx;
        c.value = val;
        c.gap = gap;
        pending_cmds.push_back(c);
        total_cmds++;
        track_len(op, idx);
    endfunction

    function automatic val_t pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic idx_t pick_index();
        case ($urandom_range(0, 9))
            7: return idx_t'(gen_len);
            8: return idx_t'($urandom_range(0, 127));
            9: return ($urandom_range(0, 1) != 0) ? 7'd127 : idx_t'(LIST_CAP);
            default: return (gen_len > 0) ? idx_t'($urandom_range(0, gen_len - 1)) : '0;
        endcase
    endfunction

    function automatic op_t pick_insert();
        case ($urandom_range(0, 2))
            0: return ilid_pkg::OP_HEAD;
            1: return ilid_pkg::OP_TAIL;
            default: return ilid_pkg::OP_AT;
        endcase
    endfunction

    function automatic op_t pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == MODE_GROW)
        begin
            if (r < 85) return pick_insert();
            return (r < 95) ? ilid_pkg::OP_READ : ilid_pkg::OP_DEL;
        end
        if (mode == MODE_SHRINK)
        begin
            if (r < 80) return ilid_pkg::OP_DEL;
            return (r < 90) ? ilid_pkg::OP_READ : pick_insert();
        end
        if (r < 20) return ilid_pkg::OP_READ;
        if (r < 35) return ilid_pkg::OP_HEAD;
        if (r < 50) return ilid_pkg::OP_TAIL;
        if (r < 65) return ilid_pkg::OP_AT;
        if (r < 90) return ilid_pkg::OP_DEL;
        return op_t'($urandom_range(5, 7));
    endfunction

    // list behavior: updates the shadow contents and returns the expected result
    function automatic list_result_t apply_command(op_t op, idx_t idx, val_t val);
        list_result_t r;
        int pos;
        r.read_value = '0;
        r.status = ilid_pkg::ST_DONE;
        pos = -1;
        case (op)
            ilid_pkg::OP_READ:
                if (int'(idx) < stored.size())
                begin
                    r.read_value = stored[idx];
                end
                else
                begin
                    r.read_value = ilid_pkg::RD_FAIL;
                    r.status = ilid_pkg::ST_RANGE;
                end
            ilid_pkg::OP_HEAD: pos = 0;
            ilid_pkg::OP_TAIL: pos = stored.size();
            ilid_pkg::OP_AT: pos = int'(idx);
            ilid_pkg::OP_DEL:
                if (int'(idx) < stored.size()) stored.delete(idx);
                else r.status = ilid_pkg::ST_RANGE;
            default: ;
        endcase
        // range is checked ahead of full
        if (pos >= 0)
        begin
            if (pos > stored.size()) r.status = ilid_pkg::ST_RANGE;
            else if (stored.size() >= LIST_CAP) r.status = ilid_pkg::ST_FULL;
            else stored.insert(pos, val);
        end
        r.count = cnt_t'(stored.size());
        return r;
    endfunction

    function automatic void report_mismatch(list_result_t want, list_result_t got, bit orphan);
        if (failures < 10)
        begin
            if (orphan)
                $display("unexpected result: read_value %0d status %0d count %0d",
                         got.read_value, got.status, got.count);
            else
                $display("mismatch: expected read_value %0d status %0d count %0d, %s %0d %0d %0d",
                         want.read_value, want.status, want.count, "got",
                         got.read_value, got.status, got.count);
        end
        failures++;
    endfunction

    // stimulus drive, changes on the falling edge
    int gap_left = -1;
    int stall_left = 0;

    always @(negedge clk)
    begin : driver
        list_cmd_t c;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && !req_fire)
            begin
                // hold the item until it is taken
            end
            else if (pending_cmds.size() > 0)
            begin
                if (gap_left < 0) gap_left = pending_cmds[0].gap;
                if (gap_left > 0)
                begin
                    req_ch.valid <= 1'b0;
                    gap_left--;
                end
                else
                begin
                    c = pending_cmds.pop_front();
                    req_ch.op <= c.op;
                    req_ch.index <= c.index;
                    req_ch.value <= c.value;
                    req_ch.valid <= 1'b1;
                    gap_left = -1;
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end

            if ($urandom_range(0, 149) == 0) stall_odds = (stall_odds == 0) ? 8 : 0;
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (pending_cmds.size() >= CALM_TAIL && $urandom_range(1, 100) <= stall_odds)
                    stall_left = $urandom_range(1, 18);
            end
        end
    end

    // sample on the rising edge: check results, then predict for the accepted item
    always @(posedge clk)
    begin : monitor
        list_result_t want;
        list_result_t got;
        bit busy;
        busy = 1'b0;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                busy = 1'b1;
                got.read_value = rsp_ch.read_value;
                got.status = rsp_ch.status;
                got.count = rsp_ch.count;
                if (expected_results.size() == 0)
                begin
                    report_mismatch(got, got, 1'b1);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want) report_mismatch(want, got, 1'b0);
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                busy = 1'b1;
                accepted_cmds++;
                expected_results.push_back(apply_command(req_ch.op, req_ch.index,
                                                         req_ch.value));
            end
            quiet_cycles <= busy ? 0 : quiet_cycles + 1;
        end
        req_fire <= rst_n && req_ch.valid && req_ch.ready;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL indexed_list_insert_delete_top");
        $finish;
    end

    initial
    begin : stimulus
        int mode;
        int phase_len;
        int made;
        req_ch.valid = 1'b0;
        req_ch.op = ilid_pkg::OP_READ;
        req_ch.index = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;

        // empty list corners, unused ops, then small list edits and reads
        add_cmd(ilid_pkg::OP_READ, 0, 0, 0);
        add_cmd(ilid_pkg::OP_READ, 127, 0, 0);
        add_cmd(ilid_pkg::OP_DEL, 0, 0, 0);
        add_cmd(3'd5, 127, -1, 0);
        add_cmd(3'd6, 0, 0, 0);
        add_cmd(3'd7, 64, 32'sh12345678, 0);
        add_cmd(ilid_pkg::OP_AT, 1, 32'sh11111111, 0);
        add_cmd(ilid_pkg::OP_TAIL, 0, 32'sh7fffffff, 0);
        add_cmd(ilid_pkg::OP_HEAD, 0, 32'sh80000000, 0);
        add_cmd(ilid_pkg::OP_AT, 2, -1, 0);
        add_cmd(ilid_pkg::OP_AT, 1, 0, 0);
        add_cmd(ilid_pkg::OP_AT, 127, 32'shaaaaaaaa, 0);
        add_cmd(ilid_pkg::OP_READ, 0, 0, 0);
        add_cmd(ilid_pkg::OP_READ, 3, 0, 0);
        add_cmd(ilid_pkg::OP_READ, 4, 0, 0);
        add_cmd(ilid_pkg::OP_DEL, 3, 0, 0);
        add_cmd(ilid_pkg::OP_DEL, 0, 0, 0);
        add_cmd(ilid_pkg::OP_DEL, 2, 0, 0);
        add_cmd(ilid_pkg::OP_TAIL, 0, 32'sh55555555, 0);
        add_cmd(ilid_pkg::OP_READ, 1, 0, 0);
        add_cmd(ilid_pkg::OP_DEL, 127, 0, 0);
        add_cmd(ilid_pkg::OP_READ, 2, 0, 0);

        // phases that fill to full, churn, and drain to empty
        made = 0;
        mode = MODE_GROW;
        while (made < RANDOM_CMDS)
        begin
            phase_len = (mode == MODE_MIX) ? $urandom_range(20, 50) : $urandom_range(70, 90);
            if (phase_len > RANDOM_CMDS - made) phase_len = RANDOM_CMDS - made;
            gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 12;
            repeat (phase_len)
            begin
                add_cmd(pick_op(mode), pick_index(), pick_value(),
                        (RANDOM_CMDS - made > CALM_TAIL && $urandom_range(1, 100) <= gap_odds)
                            ? $urandom_range(1, 18) : 0);
                made++;
            end
            mode = (mode == MODE_GROW) ? MODE_MIX : (mode == MODE_MIX) ? MODE_SHRINK : MODE_GROW;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (accepted_cmds == total_cmds);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
        begin
            $display("PASS indexed_list_insert_delete_top");
        end
        else
        begin
            $display("FAIL indexed_list_insert_delete_top");
        end
        $finish;
    end

endmodule
